@@ hdl/keypad_password_change_fsm_unit_macros.svh @@
// Assertion macros shared by the keypad password-change unit.
`ifndef KEYPAD_PASSWORD_CHANGE_FSM_UNIT_MACROS_SVH
`define KEYPAD_PASSWORD_CHANGE_FSM_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset
`define KPC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kpc assertion failed");
// Next-cycle implication, checked out of reset
`define KPC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kpc assertion failed");
`else
`define KPC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define KPC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ hdl/kpc_pkg.sv @@
// Constants and types for the keypad password-change unit.
package kpc_pkg;

  // Field widths
  localparam int unsigned KeyW      = 8;
  localparam int unsigned PwdW      = 32;
  localparam int unsigned PhaseW    = 2;
  localparam int unsigned CountW    = 3;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 32;

  // Default entry length in keys
  localparam int unsigned PassLenDef = 4;

  // Register reset values
  localparam logic [KeyW-1:0] BackspaceRst = 8'd66;
  localparam logic [PwdW-1:0] InitPwdRst   = '0;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_BACKSPACE = 1'b0,
    REG_INIT_PWD  = 1'b1
  } cfg_reg_e;

  // Event codes reported with each key
  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_WRONG    = 2'd1,
    EV_UPDATED  = 2'd2,
    EV_MISMATCH = 2'd3
  } event_e;

endpackage

@@ hdl/keypad_password_change_fsm_unit.sv @@
// Keypad password-change controller: top level.
// One key code per beat goes in, one result beat comes out per key: the phase
// after the key (old, new, confirm), the keys held in the current entry and an
// event code (wrong old password, password updated, mismatch). A key is
// registered on acceptance, and its result then goes to the output register;
// a new key is taken every cycle unless a waiting result is stalled, and the
// key index, entry and phase are all updated as the key advances. The output
// register lets a key be accepted while a result waits. Writing the initial
// password register also reloads the stored password unless a key advances.
`include "keypad_password_change_fsm_unit_macros.svh"

module keypad_password_change_fsm_unit
  import kpc_pkg::*;
#(
  parameter int unsigned PASS_LEN = PassLenDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // key channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [KeyW-1:0]     key_code_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [PhaseW-1:0]   phase_o,
  output logic [CountW-1:0]   entered_count_o,
  output logic [1:0]          event_res_o,
  // configuration write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned EntryW  = PASS_LEN * KeyW;
  localparam int unsigned IdxW    = (PASS_LEN > 1) ? $clog2(PASS_LEN) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(PASS_LEN - 1);

  typedef enum logic [PhaseW-1:0] {
    PH_OLD  = 2'd0,
    PH_NEW  = 2'd1,
    PH_CONF = 2'd2
  } phase_e;

  // input stage
  logic                in_vld_q;
  logic [KeyW-1:0]     key_q;
  logic                advance;

  // configuration
  logic [KeyW-1:0]     bs_code_q;
  logic [EntryW-1:0]   init_pwd_ext;

  // state
  phase_e              phase_q, phase_d;
  logic [IdxW-1:0]     idx_q, idx_d;
  logic [EntryW-1:0]   entry_q, entry_d;
  logic [EntryW-1:0]   new_entry_q, new_entry_d;
  logic [EntryW-1:0]   stored_q, stored_d;

  // result register
  logic                out_vld_q;
  logic [PhaseW-1:0]   out_phase_q;
  logic [CountW-1:0]   out_cnt_q;
  event_e              out_event_q, event_d;

  // working values
  logic                is_bs;
  logic                entry_done;
  logic [EntryW-1:0]   entry_wr;
  logic [EntryW-1:0]   entry_bs;
  logic [IdxW-1:0]     idx_prev;

  // initial password resized to the entry width (upper keys zero)
  assign init_pwd_ext = EntryW'(cfg_data_i);

  // stage handshake
  assign advance     = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o  = in_vld_q && !advance;

  // input register and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      key_q     <= '0;
      bs_code_q <= BackspaceRst;
    end else begin
      if (!in_stall_o) begin
        in_vld_q <= in_valid_i;
        if (in_valid_i) begin
          key_q <= key_code_i;
        end
      end
      if (cfg_we_i && (cfg_idx_i == REG_BACKSPACE)) begin
        bs_code_q <= cfg_data_i[KeyW-1:0];
      end
    end
  end

  // entry lanes: write the key at the index, clear the lane before it
  assign idx_prev = idx_q - 1'b1;
  always_comb begin
    entry_wr = entry_q;
    entry_bs = entry_q;
    for (int i = 0; i < PASS_LEN; i++) begin
      if (idx_q == IdxW'(i)) begin
        entry_wr[i*KeyW +: KeyW] = key_q;
      end
      if (idx_prev == IdxW'(i)) begin
        entry_bs[i*KeyW +: KeyW] = '0;
      end
    end
  end

  assign is_bs      = (key_q == bs_code_q);
  assign entry_done = !is_bs && (idx_q == LastIdx);

  // next state for one key
  always_comb begin
    phase_d     = phase_q;
    idx_d       = idx_q;
    entry_d     = entry_q;
    new_entry_d = new_entry_q;
    stored_d    = stored_q;
    event_d     = EV_NONE;
    if (is_bs) begin
      if (idx_q != '0) begin
        idx_d   = idx_prev;
        entry_d = entry_bs;
      end
    end else if (!entry_done) begin
      idx_d   = idx_q + 1'b1;
      entry_d = entry_wr;
    end else begin
      idx_d   = '0;
      entry_d = '0;
      case (phase_q)
        PH_NEW: begin
          new_entry_d = entry_wr;
          phase_d     = PH_CONF;
        end
        PH_CONF: begin
          phase_d = PH_OLD;
          if (entry_wr == new_entry_q) begin
            stored_d = new_entry_q;
            event_d  = EV_UPDATED;
          end else begin
            event_d = EV_MISMATCH;
          end
        end
        default: begin
          // old phase; an unreachable code is treated the same
          if (entry_wr == stored_q) begin
            phase_d = PH_NEW;
          end else begin
            phase_d = PH_OLD;
            event_d = EV_WRONG;
          end
        end
      endcase
    end
  end

  // state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_OLD;
      idx_q       <= '0;
      entry_q     <= '0;
      new_entry_q <= '0;
      stored_q    <= EntryW'(InitPwdRst);
      out_vld_q   <= 1'b0;
      out_phase_q <= '0;
      out_cnt_q   <= '0;
      out_event_q <= EV_NONE;
    end else begin
      if (advance) begin
        phase_q     <= phase_d;
        idx_q       <= idx_d;
        entry_q     <= entry_d;
        new_entry_q <= new_entry_d;
        stored_q    <= stored_d;
        out_vld_q   <= 1'b1;
        out_phase_q <= phase_d;
        out_cnt_q   <= CountW'(idx_d);
        out_event_q <= event_d;
      end else begin
        if (!out_stall_i) begin
          out_vld_q <= 1'b0;
        end
        // writing the initial password reloads the stored one (only while no key advances)
        if (cfg_we_i && (cfg_idx_i == REG_INIT_PWD)) begin
          stored_q <= init_pwd_ext;
        end
      end
    end
  end

  // outputs
  assign out_valid_o     = out_vld_q;
  assign phase_o         = out_phase_q;
  assign entered_count_o = out_cnt_q;
  assign event_res_o     = out_event_q;

  // a reported event always closes an entry and lands in the old phase
  `KPC_ASSERT_IMP(a_event_closes_entry, clk_i, rst_ni,
    out_vld_q && (out_event_q != EV_NONE),
    (out_cnt_q == '0) && (out_phase_q == PH_OLD))
  // the input stage only stalls while holding a key
  `KPC_ASSERT_IMP(a_stall_needs_key, clk_i, rst_ni, in_stall_o, in_vld_q)
  // an update event installs the confirmed new password
  `KPC_ASSERT_NXT(a_update_installs, clk_i, rst_ni,
    advance && (event_d == EV_UPDATED), stored_q == $past(new_entry_q))
  // the phase register never leaves the three legal phases
  `KPC_ASSERT_IMP(a_phase_legal, clk_i, rst_ni, out_vld_q,
    (out_phase_q == PH_OLD) || (out_phase_q == PH_NEW) || (out_phase_q == PH_CONF))

endmodule
